/* design/obb_cr_pkg.sv */
`default_nettype none
package obb_cr_pkg;

  localparam int VERTEX_COUNT = 4;
  localparam int COORD_BITS   = 32;
  localparam int CW           = (COORD_BITS > 32) ? 32 : COORD_BITS;
  localparam int VIDX_W       = $clog2(VERTEX_COUNT);

  localparam int MEL_W      = 17;
  localparam int MEL_SQ_W   = 2 * MEL_W;
  localparam int UNIT_W     = 18;
  localparam int DEPTH_W    = 31;
  localparam int POS_W      = 32;
  localparam int PR_W       = 53;
  localparam int SQ_IN_W    = 62;
  localparam int ROOT_W     = 31;
  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS  = 17;
  localparam int CNT_W      = 5;
  localparam int MAG_W      = 30;

  localparam int IN_DATA_W  = 64 * VERTEX_COUNT + 64;
  localparam int OUT_DATA_W = 200;

  typedef enum logic [1:0] {
    MUL_SQ,
    MUL_PROJ,
    MUL_DOT,
    MUL_CORR
  } mul_op_t;

  typedef struct packed {
    logic              load_first;
    logic              load_second;
    logic              rd_sel;
    logic [VIDX_W-1:0] rd_idx;
    logic              edge_latch;
    logic              edge_calc;
    logic              mul_en;
    mul_op_t           mul_op;
    logic              sqrt_init;
    logic              sqrt_step;
    logic              div_init;
    logic              div_step;
    logic              unit_set;
    logic              proj_issue;
    logic              proj_first;
    logic              ovl_eval;
    logic              best_clear;
    logic              fin_init;
    logic              fin_miss;
    logic              dot_eval;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic held_valid;
    logic skip;
    logic ov_nonpos;
  } status_t;

endpackage
`default_nettype wire

/* design/obb_cr_dp.sv */
`default_nettype none
module obb_cr_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [obb_cr_pkg::IN_DATA_W-1:0]    in_data,
  input  wire logic                                in_kind,
  input  wire logic                                cfg_we,
  input  wire logic [obb_cr_pkg::MEL_W-1:0]        cfg_data,
  input  wire obb_cr_pkg::cmd_t                    cmd,
  output obb_cr_pkg::status_t                      status,
  output logic                                     out_hit,
  output logic [obb_cr_pkg::OUT_DATA_W-1:0]        out_data
);

  localparam int V = obb_cr_pkg::VERTEX_COUNT;

  function automatic logic signed [31:0] to_coord(input logic [31:0] v);
    return 32'($signed(v[obb_cr_pkg::CW-1:0]));
  endfunction

  function automatic logic signed [31:0] sat_coord(input logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'((64'sd1 <<< (obb_cr_pkg::CW - 1)) - 64'sd1);
    lo = -hi - 50'sd1;
    if (v > hi) return 32'(hi);
    else if (v < lo) return 32'(lo);
    return 32'(v);
  endfunction

  // round to nearest, ties away from zero
  function automatic logic signed [49:0] round_shift(input logic signed [49:0] v,
                                                     input logic half);
    logic [49:0] m;
    m = v[49] ? 50'(-v) : 50'(v);
    m = half ? ((m + 50'd65536) >> 17) : ((m + 50'd32768) >> 16);
    return v[49] ? -$signed(m) : $signed(m);
  endfunction

  // stored polygons
  logic signed [31:0] hx_r [V];
  logic signed [31:0] hy_r [V];
  logic signed [31:0] tx_r [V];
  logic signed [31:0] ty_r [V];
  logic signed [31:0] hpx_r, hpy_r, tpx_r, tpy_r;
  logic               hkind_r, tkind_r, held_valid_r;
  logic [obb_cr_pkg::MEL_SQ_W-1:0] mel_sq_r;

  // edge / unit vector
  logic signed [31:0] ex0_r, ey0_r;
  logic [obb_cr_pkg::MAG_W-1:0] a_r, b_r;
  logic small_r, zero_r, dxneg_r, dypos_r;

  logic [obb_cr_pkg::SQ_IN_W-1:0] sq_x_r;
  logic [33:0]                    sq_rem_r;
  logic [obb_cr_pkg::ROOT_W-1:0]  sq_root_r;

  logic [31:0] dv_rem0_r, dv_rem1_r;
  logic [16:0] dv_lo0_r, dv_lo1_r, dv_q0_r, dv_q1_r;

  logic signed [obb_cr_pkg::UNIT_W-1:0] ux_r, uy_r, bx_r, by_r;

  logic signed [63:0] prod0_r, prod1_r;
  logic               tag_v_r, tag_sel_r, tag_first_r;
  logic signed [obb_cr_pkg::PR_W-1:0] lo_r [2];
  logic signed [obb_cr_pkg::PR_W-1:0] hi_r [2];
  logic signed [obb_cr_pkg::PR_W-1:0] best_r;
  logic                               have_r;

  logic                              miss_r;
  logic [obb_cr_pkg::DEPTH_W-1:0]    depth_r;
  logic signed [31:0]                fx_r, fy_r;

  logic                              o_hit_r;
  logic signed [obb_cr_pkg::UNIT_W-1:0] o_ax_r, o_ay_r;
  logic [obb_cr_pkg::DEPTH_W-1:0]    o_depth_r;
  logic signed [31:0]                o_fx_r, o_fy_r, o_sx_r, o_sy_r;
  logic signed [31:0]                o_fx_nxt, o_fy_nxt, o_sx_nxt, o_sy_nxt;

  // combinational
  logic signed [31:0] rx, ry;
  logic signed [32:0] dx, dy;
  logic [32:0]        adx, ady, mx;
  logic [1:0]         sh;
  logic [obb_cr_pkg::SQ_IN_W-1:0] s2;
  logic signed [32:0] ma0, ma1;
  logic signed [30:0] mb0, mb1;
  logic [35:0]        sq_t, sq_try;
  logic [46:0]        num0, num1;
  logic [32:0]        dt0, dt1;
  logic signed [obb_cr_pkg::PR_W-1:0] pr, ov, hmin, lmax;
  logic [36:0]        dd;
  logic signed [49:0] cx, cy, rsx, rsy;

  always_comb begin
    rx = cmd.rd_sel ? tx_r[cmd.rd_idx] : hx_r[cmd.rd_idx];
    ry = cmd.rd_sel ? ty_r[cmd.rd_idx] : hy_r[cmd.rd_idx];
    dx = 33'(rx) - 33'(ex0_r);
    dy = 33'(ry) - 33'(ey0_r);
    adx = dx[32] ? 33'(-dx) : 33'(dx);
    ady = dy[32] ? 33'(-dy) : 33'(dy);
    mx = (adx > ady) ? adx : ady;
    if (mx[32]) sh = 2'd3;
    else if (mx[31]) sh = 2'd2;
    else if (mx[30]) sh = 2'd1;
    else sh = 2'd0;

    s2 = prod0_r[obb_cr_pkg::SQ_IN_W-1:0] + prod1_r[obb_cr_pkg::SQ_IN_W-1:0];

    unique case (cmd.mul_op)
      obb_cr_pkg::MUL_SQ: begin
        ma0 = 33'($signed({1'b0, a_r}));
        mb0 = 31'($signed({1'b0, a_r}));
        ma1 = 33'($signed({1'b0, b_r}));
        mb1 = 31'($signed({1'b0, b_r}));
      end
      obb_cr_pkg::MUL_PROJ: begin
        ma0 = 33'(rx);
        mb0 = 31'(ux_r);
        ma1 = 33'(ry);
        mb1 = 31'(uy_r);
      end
      obb_cr_pkg::MUL_DOT: begin
        ma0 = 33'(tpx_r) - 33'(fx_r);
        mb0 = 31'(bx_r);
        ma1 = 33'(tpy_r) - 33'(fy_r);
        mb1 = 31'(by_r);
      end
      default: begin
        ma0 = 33'($signed({1'b0, depth_r}));
        mb0 = 31'(bx_r);
        ma1 = 33'($signed({1'b0, depth_r}));
        mb1 = 31'(by_r);
      end
    endcase

    sq_t   = {sq_rem_r, sq_x_r[obb_cr_pkg::SQ_IN_W-1 -: 2]};
    sq_try = 36'({sq_root_r, 2'b01});

    num0 = {1'b0, b_r, 16'b0} + 47'(sq_root_r >> 1);
    num1 = {1'b0, a_r, 16'b0} + 47'(sq_root_r >> 1);
    dt0  = {dv_rem0_r, dv_lo0_r[16]};
    dt1  = {dv_rem1_r, dv_lo1_r[16]};

    pr   = $signed(prod0_r[obb_cr_pkg::PR_W-1:0]) + $signed(prod1_r[obb_cr_pkg::PR_W-1:0]);
    hmin = (hi_r[0] < hi_r[1]) ? hi_r[0] : hi_r[1];
    lmax = (lo_r[0] > lo_r[1]) ? lo_r[0] : lo_r[1];
    ov   = hmin - lmax;

    dd = 37'((best_r + 53'sd32768) >>> 16);

    cx  = $signed(prod0_r[49:0]);
    cy  = $signed(prod1_r[49:0]);
    rsx = round_shift(cx, hkind_r & tkind_r);
    rsy = round_shift(cy, hkind_r & tkind_r);

    o_fx_nxt = fx_r;
    o_fy_nxt = fy_r;
    o_sx_nxt = tpx_r;
    o_sy_nxt = tpy_r;
    if (!miss_r) begin
      if (!hkind_r && tkind_r) begin
        o_sx_nxt = sat_coord(50'(tpx_r) + rsx);
        o_sy_nxt = sat_coord(50'(tpy_r) + rsy);
      end else if (hkind_r && !tkind_r) begin
        o_fx_nxt = sat_coord(50'(fx_r) - rsx);
        o_fy_nxt = sat_coord(50'(fy_r) - rsy);
      end else if (hkind_r && tkind_r) begin
        o_fx_nxt = sat_coord(50'(fx_r) - rsx);
        o_fy_nxt = sat_coord(50'(fy_r) - rsy);
        o_sx_nxt = sat_coord(50'(tpx_r) + rsx);
        o_sy_nxt = sat_coord(50'(tpy_r) + rsy);
      end
    end

    status.held_valid = held_valid_r;
    status.skip = zero_r ||
                  (small_r && (s2 < obb_cr_pkg::SQ_IN_W'(mel_sq_r)));
    status.ov_nonpos = (ov <= 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      hkind_r      <= 1'b0;
      mel_sq_r     <= obb_cr_pkg::MEL_SQ_W'(1);
      tag_v_r      <= 1'b0;
      have_r       <= 1'b0;
    end else begin
      if (cfg_we) mel_sq_r <= obb_cr_pkg::MEL_SQ_W'(cfg_data) * obb_cr_pkg::MEL_SQ_W'(cfg_data);
      if (cmd.load_first) begin
        held_valid_r <= 1'b1;
        hkind_r      <= in_kind;
      end
      tag_v_r <= cmd.proj_issue;
      if (cmd.best_clear) have_r <= 1'b0;
      else if (cmd.ovl_eval && (ov > 0) && (!have_r || ov < best_r)) have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < V; i++) begin
      if (cmd.load_first) begin
        hx_r[i] <= to_coord(in_data[64*i +: 32]);
        hy_r[i] <= to_coord(in_data[64*i+32 +: 32]);
      end
      if (cmd.load_second) begin
        tx_r[i] <= to_coord(in_data[64*i +: 32]);
        ty_r[i] <= to_coord(in_data[64*i+32 +: 32]);
      end
    end
    if (cmd.load_first) begin
      hpx_r <= to_coord(in_data[64*V +: 32]);
      hpy_r <= to_coord(in_data[64*V+32 +: 32]);
    end
    if (cmd.load_second) begin
      tpx_r   <= to_coord(in_data[64*V +: 32]);
      tpy_r   <= to_coord(in_data[64*V+32 +: 32]);
      tkind_r <= in_kind;
    end

    if (cmd.edge_latch) begin
      ex0_r <= rx;
      ey0_r <= ry;
    end
    if (cmd.edge_calc) begin
      a_r     <= obb_cr_pkg::MAG_W'(adx >> sh);
      b_r     <= obb_cr_pkg::MAG_W'(ady >> sh);
      small_r <= (adx < 33'd262144) && (ady < 33'd262144);
      zero_r  <= (adx == '0) && (ady == '0);
      dxneg_r <= dx[32];
      dypos_r <= !dy[32] && (dy != '0);
    end

    if (cmd.mul_en) begin
      prod0_r <= 64'(ma0) * 64'(mb0);
      prod1_r <= 64'(ma1) * 64'(mb1);
    end

    // digit-by-digit square root, two input bits per step
    if (cmd.sqrt_init) begin
      sq_x_r    <= s2;
      sq_rem_r  <= '0;
      sq_root_r <= '0;
    end else if (cmd.sqrt_step) begin
      sq_x_r <= sq_x_r << 2;
      if (sq_t >= sq_try) begin
        sq_rem_r  <= 34'(sq_t - sq_try);
        sq_root_r <= {sq_root_r[obb_cr_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem_r  <= 34'(sq_t);
        sq_root_r <= {sq_root_r[obb_cr_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    // quotient fits in 17 bits, so the upper numerator bits start as remainder
    if (cmd.div_init) begin
      dv_rem0_r <= 32'(num0[46:17]);
      dv_lo0_r  <= num0[16:0];
      dv_rem1_r <= 32'(num1[46:17]);
      dv_lo1_r  <= num1[16:0];
      dv_q0_r   <= '0;
      dv_q1_r   <= '0;
    end else if (cmd.div_step) begin
      dv_lo0_r <= dv_lo0_r << 1;
      dv_lo1_r <= dv_lo1_r << 1;
      if (dt0 >= 33'(sq_root_r)) begin
        dv_rem0_r <= 32'(dt0 - 33'(sq_root_r));
        dv_q0_r   <= {dv_q0_r[15:0], 1'b1};
      end else begin
        dv_rem0_r <= 32'(dt0);
        dv_q0_r   <= {dv_q0_r[15:0], 1'b0};
      end
      if (dt1 >= 33'(sq_root_r)) begin
        dv_rem1_r <= 32'(dt1 - 33'(sq_root_r));
        dv_q1_r   <= {dv_q1_r[15:0], 1'b1};
      end else begin
        dv_rem1_r <= 32'(dt1);
        dv_q1_r   <= {dv_q1_r[15:0], 1'b0};
      end
    end

    if (cmd.unit_set) begin
      ux_r <= dypos_r ? -$signed({1'b0, dv_q0_r}) : $signed({1'b0, dv_q0_r});
      uy_r <= dxneg_r ? -$signed({1'b0, dv_q1_r}) : $signed({1'b0, dv_q1_r});
    end

    if (cmd.proj_issue) begin
      tag_sel_r   <= cmd.rd_sel;
      tag_first_r <= cmd.proj_first;
    end
    if (tag_v_r) begin
      if (tag_first_r || pr < lo_r[tag_sel_r]) lo_r[tag_sel_r] <= pr;
      if (tag_first_r || pr > hi_r[tag_sel_r]) hi_r[tag_sel_r] <= pr;
    end

    if (cmd.ovl_eval && (ov > 0) && (!have_r || ov < best_r)) begin
      best_r <= ov;
      bx_r   <= ux_r;
      by_r   <= uy_r;
    end

    if (cmd.fin_init) begin
      miss_r <= cmd.fin_miss || !have_r;
      fx_r   <= held_valid_r ? hpx_r : '0;
      fy_r   <= held_valid_r ? hpy_r : '0;
      if (cmd.fin_miss || !have_r) begin
        bx_r    <= '0;
        by_r    <= '0;
        depth_r <= '0;
      end else begin
        depth_r <= (dd > 37'h7FFFFFFF) ? 31'h7FFFFFFF : dd[30:0];
      end
    end

    if (cmd.dot_eval && (pr < 0)) begin
      bx_r <= -bx_r;
      by_r <= -by_r;
    end

    if (cmd.out_load) begin
      o_hit_r   <= !miss_r;
      o_ax_r    <= bx_r;
      o_ay_r    <= by_r;
      o_depth_r <= depth_r;
      o_fx_r    <= o_fx_nxt;
      o_fy_r    <= o_fy_nxt;
      o_sx_r    <= o_sx_nxt;
      o_sy_r    <= o_sy_nxt;
    end
  end

  assign out_hit  = o_hit_r;
  assign out_data = {5'b0, o_sy_r, o_sx_r, o_fy_r, o_fx_r, o_depth_r, o_ay_r, o_ax_r};

endmodule
`default_nettype wire

/* design/obb_cr_ctrl.sv */
`default_nettype none
module obb_cr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_which,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire obb_cr_pkg::status_t  status,
  output obb_cr_pkg::cmd_t          cmd
);

  localparam logic [obb_cr_pkg::VIDX_W-1:0] LAST_V =
    obb_cr_pkg::VIDX_W'(obb_cr_pkg::VERTEX_COUNT - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_E0, S_E1, S_SQ, S_SUM, S_SQRT, S_DIVI, S_DIV, S_UNIT,
    S_PROJ, S_DRAIN, S_OVL, S_FIN, S_DOTI, S_DOTE, S_CORR, S_OUT
  } state_t;

  state_t                          state_r;
  logic                            q_r, psel_r, miss_r, out_valid_r;
  logic [obb_cr_pkg::VIDX_W-1:0]   e_r, pidx_r, e_nxt;
  logic [obb_cr_pkg::CNT_W-1:0]    cnt_r;
  logic                            accept, last_axis;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign e_nxt     = (e_r == LAST_V) ? '0 : e_r + 1'b1;
  assign last_axis = q_r && (e_r == LAST_V);

  always_comb begin
    cmd = '0;
    cmd.mul_op = obb_cr_pkg::MUL_SQ;
    cmd.rd_sel = q_r;
    cmd.rd_idx = e_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.load_first  = accept && !in_which;
        cmd.load_second = accept && in_which;
        cmd.best_clear  = accept;
      end
      S_E0:   cmd.edge_latch = 1'b1;
      S_E1: begin
        cmd.rd_idx    = e_nxt;
        cmd.edge_calc = 1'b1;
      end
      S_SQ:   cmd.mul_en = 1'b1;
      S_SUM:  cmd.sqrt_init = 1'b1;
      S_SQRT: cmd.sqrt_step = 1'b1;
      S_DIVI: cmd.div_init = 1'b1;
      S_DIV:  cmd.div_step = 1'b1;
      S_UNIT: cmd.unit_set = 1'b1;
      S_PROJ: begin
        cmd.rd_sel     = psel_r;
        cmd.rd_idx     = pidx_r;
        cmd.mul_en     = 1'b1;
        cmd.mul_op     = obb_cr_pkg::MUL_PROJ;
        cmd.proj_issue = 1'b1;
        cmd.proj_first = (pidx_r == '0);
      end
      S_DRAIN: ;
      S_OVL:  cmd.ovl_eval = 1'b1;
      S_FIN: begin
        cmd.fin_init = 1'b1;
        cmd.fin_miss = miss_r;
      end
      S_DOTI: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = obb_cr_pkg::MUL_DOT;
      end
      S_DOTE: cmd.dot_eval = 1'b1;
      S_CORR: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = obb_cr_pkg::MUL_CORR;
      end
      S_OUT:  cmd.out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      q_r         <= 1'b0;
      e_r         <= '0;
      psel_r      <= 1'b0;
      pidx_r      <= '0;
      cnt_r       <= '0;
      miss_r      <= 1'b0;
    end else begin
      // in S_OUT the result register is either loaded or still pending
      if (state_r == S_OUT) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          q_r    <= 1'b0;
          e_r    <= '0;
          miss_r <= accept && in_which && !status.held_valid;
          if (accept && in_which) begin
            if (!status.held_valid) state_r <= S_FIN;
            else state_r <= S_E0;
          end
        end
        S_E0: state_r <= S_E1;
        S_E1: state_r <= S_SQ;
        S_SQ: state_r <= S_SUM;
        S_SUM: begin
          cnt_r <= '0;
          if (status.skip) begin
            if (last_axis) state_r <= S_FIN;
            else state_r <= S_E0;
            q_r <= q_r | (e_r == LAST_V);
            e_r <= e_nxt;
          end else begin
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == obb_cr_pkg::CNT_W'(obb_cr_pkg::SQRT_STEPS - 1)) state_r <= S_DIVI;
        end
        S_DIVI: begin
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == obb_cr_pkg::CNT_W'(obb_cr_pkg::DIV_STEPS - 1)) state_r <= S_UNIT;
        end
        S_UNIT: begin
          psel_r  <= 1'b0;
          pidx_r  <= '0;
          state_r <= S_PROJ;
        end
        S_PROJ: begin
          if (pidx_r == LAST_V) begin
            pidx_r <= '0;
            psel_r <= 1'b1;
            if (psel_r) state_r <= S_DRAIN;
          end else begin
            pidx_r <= pidx_r + 1'b1;
          end
        end
        S_DRAIN: state_r <= S_OVL;
        S_OVL: begin
          if (status.ov_nonpos) begin
            miss_r  <= 1'b1;
            state_r <= S_FIN;
          end else begin
            if (last_axis) state_r <= S_FIN;
            else state_r <= S_E0;
            q_r <= q_r | (e_r == LAST_V);
            e_r <= e_nxt;
          end
        end
        S_FIN:  state_r <= S_DOTI;
        S_DOTI: state_r <= S_DOTE;
        S_DOTE: state_r <= S_CORR;
        S_CORR: state_r <= S_OUT;
        S_OUT: begin
          if (!out_valid_r || out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result register is never overwritten while a transaction is pending
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && out_valid_r) |-> out_ready)
    else $error("result overwritten while pending");

  // a test item with a held quad always starts at the first edge
  a_test_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_which && status.held_valid) |=> (state_r == S_E0 && !q_r && e_r == '0))
    else $error("test did not start at first edge");

  // a stored first quad produces no result
  a_store_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_which) |=> (state_r == S_IDLE))
    else $error("store item left idle");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < obb_cr_pkg::CNT_W'(obb_cr_pkg::DIV_STEPS)))
    else $error("divider overran");

endmodule
`default_nettype wire

/* design/obb_collision_resolve_unit.sv */
// Separating-axis collision of two quads with minimum-translation resolution.
// Input stream (in_*): one transaction carries one quad. in_tuser[0] = 0 stores
// it as the first quad (no result); in_tuser[0] = 1 tests it against the stored
// quad and gives exactly one result transaction on out_*.
// Config (cfg_*): min_edge_length, written while the unit is idle; cfg_ready is
// always high. Reset value is 1.
// A test tries the edges of both quads as axes. Each non-skipped one forms the edge,
// runs the bit-serial square root and the two parallel restoring dividers, sets
// the unit axis, projects both quads on the shared pair of multipliers and checks
// the overlap. A skipped edge leaves once its squared length is formed. The
// finish sets the depth, orients the axis and forms the correction.
// One item is in flight at a time; in_tready is high only when idle.
// The result sits in an output register: the unit takes the next item while it
// waits, and stalls before loading a new result until out_tready takes the old.
// Reset (rst_n, synchronous) drops any held quad and pending result.
`default_nettype none
module obb_collision_resolve_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, v3_x, v3_y, pos_x, pos_y
  input  wire logic [319:0] in_tdata,
  // which_quad, body_kind
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // axis_x, axis_y, depth, first_new_x, first_new_y, second_new_x, second_new_y, pad
  output logic [199:0]      out_tdata,
  // hit
  output logic [0:0]        out_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [16:0]  cfg_data
);

  obb_cr_pkg::cmd_t    cmd;
  obb_cr_pkg::status_t status;

  assign cfg_ready = 1'b1;

  obb_cr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_which  (in_tuser[0]),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .status    (status),
    .cmd       (cmd)
  );

  obb_cr_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_tdata),
    .in_kind  (in_tuser[1]),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .status   (status),
    .out_hit  (out_tuser[0]),
    .out_data (out_tdata)
  );

endmodule
`default_nettype wire

/* verif/obb_collision_resolve_unit_tb.sv */
`timescale 1ns / 1ps
module obb_collision_resolve_unit_tb;

  localparam int NV        = 4;
  localparam int WDOG_MAX  = 8000;
  localparam bit FIRST_Q   = 1'b0;
  localparam bit SECOND_Q  = 1'b1;
  localparam bit STATIC_B  = 1'b0;
  localparam bit DYNAMIC_B = 1'b1;

  typedef struct {
    int c[2*NV+2];   // v0_x .. v3_y, pos_x, pos_y
    bit which;
    bit kind;
  } quad_t;

  typedef struct {
    bit                hit;
    logic [17:0]       ax, ay;
    logic [30:0]       depth;
    logic [31:0]       fx, fy, sx, sy;
  } resolve_t;

  logic         clk, rst_n;
  logic         in_tvalid, in_tready;
  logic [319:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid, out_tready;
  logic [199:0] out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_valid, cfg_ready;
  logic [16:0]  cfg_data;

  obb_collision_resolve_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // shadow of the unit's state
  longint  held_v[2*NV];
  longint  held_px, held_py;
  bit      held_kind, held_ok;
  longint  min_edge;

  resolve_t expected_q[$];
  int       errors;
  bit       no_stall_phase;
  int       idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned sqrt_floor(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    longint m;
    m = (absl(v) + (64'sd1 << (s - 1))) >>> s;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unit_part(longint unsigned m, longint unsigned r, bit neg);
    longint q;
    q = longint'((m * 65536 + r / 2) / r);
    return neg ? -q : q;
  endfunction

  // separating-axis test plus position correction; updates the held quad on a store
  function automatic bit resolve_quads(quad_t it, output resolve_t res);
    longint sv[2*NV], pl[2][2*NV];
    longint best, bx, by, fx, fy, sx, sy, dx, dy, ux, uy, ov, pr, cx, cy;
    longint lo[2], hi[2];
    longint unsigned adx, ady, m, a, b, r, dd, dep;
    bit have, miss;
    int s, n;
    for (int i = 0; i < 2*NV; i++) sv[i] = longint'(it.c[i]);
    if (it.which == FIRST_Q) begin
      held_v = sv;
      held_px = it.c[2*NV];
      held_py = it.c[2*NV+1];
      held_kind = it.kind;
      held_ok = 1'b1;
      return 1'b0;
    end
    pl[0] = held_v;
    pl[1] = sv;
    have = 1'b0;
    miss = !held_ok;
    best = 0; bx = 0; by = 0; dep = 0;
    for (int q = 0; q < 2 && !miss; q++) begin
      for (int e = 0; e < NV && !miss; e++) begin
        n = (e + 1) % NV;
        dx = pl[q][2*n] - pl[q][2*e];
        dy = pl[q][2*n+1] - pl[q][2*e+1];
        adx = absl(dx);
        ady = absl(dy);
        if (adx == 0 && ady == 0) continue;
        if (adx < (1 << 18) && ady < (1 << 18) &&
            adx * adx + ady * ady < min_edge * min_edge) continue;
        m = adx > ady ? adx : ady;
        s = 0;
        while ((m >> s) >= (64'd1 << 30)) s++;
        a = adx >> s;
        b = ady >> s;
        r = sqrt_floor(a * a + b * b);
        ux = unit_part(b, r, dy > 0);
        uy = unit_part(a, r, dx < 0);
        for (int p = 0; p < 2; p++) begin
          for (int k = 0; k < NV; k++) begin
            pr = pl[p][2*k] * ux + pl[p][2*k+1] * uy;
            if (k == 0 || pr < lo[p]) lo[p] = pr;
            if (k == 0 || pr > hi[p]) hi[p] = pr;
          end
        end
        ov = (hi[0] < hi[1] ? hi[0] : hi[1]) - (lo[0] > lo[1] ? lo[0] : lo[1]);
        if (ov <= 0) begin
          miss = 1'b1;
          break;
        end
        if (!have || ov < best) begin
          best = ov; bx = ux; by = uy; have = 1'b1;
        end
      end
    end
    if (!have) miss = 1'b1;
    fx = held_ok ? held_px : 0;
    fy = held_ok ? held_py : 0;
    sx = it.c[2*NV];
    sy = it.c[2*NV+1];
    if (miss) begin
      bx = 0; by = 0;
    end else begin
      dd = (unsigned'(best) + 32768) >> 16;
      dep = dd > 64'h7FFFFFFF ? 64'h7FFFFFFF : dd;
      if ((sx - fx) * bx + (sy - fy) * by < 0) begin
        bx = -bx; by = -by;
      end
      cx = bx * longint'(dep);
      cy = by * longint'(dep);
      if (held_kind == STATIC_B && it.kind == DYNAMIC_B) begin
        sx = sat32(sx + rnd_shift(cx, 16));
        sy = sat32(sy + rnd_shift(cy, 16));
      end else if (held_kind == DYNAMIC_B && it.kind == STATIC_B) begin
        fx = sat32(fx - rnd_shift(cx, 16));
        fy = sat32(fy - rnd_shift(cy, 16));
      end else if (held_kind == DYNAMIC_B && it.kind == DYNAMIC_B) begin
        fx = sat32(fx - rnd_shift(cx, 17));
        fy = sat32(fy - rnd_shift(cy, 17));
        sx = sat32(sx + rnd_shift(cx, 17));
        sy = sat32(sy + rnd_shift(cy, 17));
      end
    end
    res.hit = !miss;
    res.ax = bx[17:0];
    res.ay = by[17:0];
    res.depth = dep[30:0];
    res.fx = fx[31:0];
    res.fy = fy[31:0];
    res.sx = sx[31:0];
    res.sy = sy[31:0];
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (no_stall_phase) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_quad(quad_t it);
    resolve_t r;
    int gap;
    @(negedge clk);
    for (int i = 0; i < 2*NV+2; i++) in_tdata[32*i +: 32] = it.c[i];
    in_tuser = {it.kind, it.which};
    in_tvalid = 1'b1;
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    if (resolve_quads(it, r)) expected_q.push_back(r);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_min_edge(logic [16:0] val);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_data = val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    min_edge = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // roughly convex quad, one vertex per quadrant around the center
  function automatic quad_t make_quad(bit which, bit kind, int cx, int cy, int ext);
    quad_t q;
    q.which = which;
    q.kind = kind;
    q.c[0] = cx - int'($urandom_range(1, ext)); q.c[1] = cy - int'($urandom_range(1, ext));
    q.c[2] = cx + int'($urandom_range(1, ext)); q.c[3] = cy - int'($urandom_range(1, ext));
    q.c[4] = cx + int'($urandom_range(1, ext)); q.c[5] = cy + int'($urandom_range(1, ext));
    q.c[6] = cx - int'($urandom_range(1, ext)); q.c[7] = cy + int'($urandom_range(1, ext));
    q.c[8] = cx;
    q.c[9] = cy;
    return q;
  endfunction

  function automatic quad_t noise_quad();
    quad_t q;
    for (int i = 0; i < 2*NV+2; i++) q.c[i] = $urandom;
    q.which = $urandom_range(0, 1);
    q.kind = $urandom_range(0, 1);
    return q;
  endfunction

  task automatic test_no_held_quad();
    send_quad(make_quad(SECOND_Q, DYNAMIC_B, 0, 0, 65536));
  endtask

  task automatic test_body_kinds();
    for (int k = 0; k < 4; k++) begin
      send_quad(make_quad(FIRST_Q, k[1], 0, 0, 4 << 16));
      send_quad(make_quad(SECOND_Q, k[0], 65536, -32768, 4 << 16));
    end
    // clear separation gives a miss
    send_quad(make_quad(SECOND_Q, DYNAMIC_B, 40 << 16, 40 << 16, 2 << 16));
  endtask

  task automatic test_edge_lengths();
    quad_t q;
    q = make_quad(FIRST_Q, STATIC_B, 0, 0, 8);
    send_quad(q);
    q.which = SECOND_Q;
    send_quad(q);                              // tiny edges, still tested at reset length
    write_min_edge(17'd0);
    send_quad(q);
    for (int i = 0; i < 8; i++) q.c[i] = 1000;
    send_quad(q);                              // zero-length edges only
    write_min_edge(17'd65536);
    send_quad(make_quad(SECOND_Q, DYNAMIC_B, 0, 0, 1 << 14));
    send_quad(make_quad(SECOND_Q, DYNAMIC_B, 0, 0, 3 << 16));
  endtask

  task automatic test_saturation();
    quad_t q;
    q = make_quad(FIRST_Q, DYNAMIC_B, 0, 0, 32'h3FFF_FFFF);
    q.c[8] = 32'h7FFF_FF00;
    q.c[9] = 32'h8000_0100;
    send_quad(q);
    q = make_quad(SECOND_Q, DYNAMIC_B, 0, 0, 32'h3FFF_FFFF);
    q.c[8] = 32'h8000_0000;
    q.c[9] = 32'h7FFF_FFFF;
    send_quad(q);
    q.c = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h8000_0000};
    q.kind = STATIC_B;
    send_quad(q);
  endtask

  task automatic test_random(int count);
    quad_t q;
    int cx, cy, ext, roll;
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) no_stall_phase = ($urandom_range(0, 3) == 0);
      if (n % 300 == 150)
        write_min_edge(n < 400 ? 17'($urandom_range(0, 65536)) : 17'd65536);
      roll = $urandom_range(0, 99);
      ext = (roll < 50) ? $urandom_range(2, 1 << 20) : $urandom_range(16, 1 << 28);
      cx = $urandom_range(0, 1 << 22) - (1 << 21);
      cy = $urandom_range(0, 1 << 22) - (1 << 21);
      if (roll < 20) begin
        send_quad(noise_quad());
      end else if (roll < 35) begin
        send_quad(make_quad(FIRST_Q, $urandom_range(0, 1), cx, cy, ext));
      end else begin
        if (roll > 90) begin
          q = make_quad(SECOND_Q, $urandom_range(0, 1), held_px[31:0], held_py[31:0], 64);
          q.c[4] = q.c[2];                    // collapse an edge
          q.c[5] = q.c[3];
        end else begin
          q = make_quad(SECOND_Q, $urandom_range(0, 1),
                        held_px[31:0] + int'($urandom_range(0, ext)) - ext / 2,
                        held_py[31:0] + int'($urandom_range(0, ext)) - ext / 2, ext);
        end
        if ($urandom_range(0, 9) == 0) q.c[8] = $urandom;
        send_quad(q);
      end
    end
    write_min_edge(17'd1);
  endtask

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    resolve_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result transaction %h", $time, out_tdata);
        errors++;
      end else begin
        e = expected_q.pop_front();
        check_field("hit", e.hit, out_tuser[0]);
        check_field("axis_x", e.ax, out_tdata[17:0]);
        check_field("axis_y", e.ay, out_tdata[35:18]);
        check_field("depth", e.depth, out_tdata[66:36]);
        check_field("first_new_x", e.fx, out_tdata[98:67]);
        check_field("first_new_y", e.fy, out_tdata[130:99]);
        check_field("second_new_x", e.sx, out_tdata[162:131]);
        check_field("second_new_y", e.sy, out_tdata[194:163]);
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    if (no_stall_phase || $urandom_range(0, 99) < 60) out_tready <= 1'b1;
    else if ($urandom_range(0, 19) == 0) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 1) == 1);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_MAX) begin
      $display("obb_collision_resolve_unit: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    errors = 0;
    idle_cycles = 0;
    no_stall_phase = 1'b0;
    held_ok = 1'b0;
    held_kind = STATIC_B;
    held_px = 0;
    held_py = 0;
    min_edge = 1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_no_held_quad();
    test_body_kinds();
    test_edge_lengths();
    test_saturation();
    test_random(930);

    wait_drained();
    if (errors == 0)
      $display("obb_collision_resolve_unit: match");
    else
      $display("obb_collision_resolve_unit: mismatch");
    $finish;
  end

endmodule
